// File: hdl/wpq_pkg.sv
// wpq_pkg: shared types and constants of the weighted peer quantile block.
// No dependencies.
`default_nettype none
package wpq_pkg;
  localparam int unsigned OneQ = 65536;
  localparam int unsigned NumRegs = 6;
  localparam logic [2:0] RegType = 3'd0;
  localparam logic [2:0] RegNumTaus = 3'd1;
  localparam logic [2:0] RegTau0 = 3'd2;
  localparam logic [2:0] RegTau1 = 3'd3;
  localparam logic [2:0] RegTau2 = 3'd4;
  localparam logic [2:0] RegTau3 = 3'd5;

  typedef enum logic [3:0] {
    StIdle, StShiftRd, StShiftWr, StInsert, StLastChk,
    StScanRd, StScanCmp, StDivide, StPosition, StRdLo, StRdHi,
    StMul, StEmit, StNoPeer
  } state_e;
endpackage
`default_nettype wire

// File: hdl/wpq_mem.sv
// wpq_mem: peer memory holding sorted value, weight pairs.
// Uses wpq_pkg; one write port, one registered read port.
`default_nettype none
module wpq_mem import wpq_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wval_i,
  input  wire logic [15:0]   wwt_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rval_o,
  output logic      [15:0]   rwt_o
);
  logic [47:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wval_i, wwt_i};
    end
    {rval_o, rwt_o} <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hdl/wpq_div.sv
// wpq_div: restoring divider, one quotient bit per cycle.
// Uses wpq_pkg for the house import only.
`default_nettype none
module wpq_div import wpq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [38:0] num_i,
  input  wire logic [21:0] den_i,
  output logic             busy_o,
  output logic      [38:0] quo_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [38:0] quo_q, quo_d;
  logic [22:0] rem_q, rem_d;
  logic [21:0] den_q, den_d;
  logic [22:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q[21:0], quo_q[38]};
    if (start_i) begin
      cnt_d = 6'd39;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[37:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[37:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// File: hdl/weighted_peer_quantile.sv
// Weighted peer quantile: peers are inserted into a sorted memory by shifting larger
// entries up one place each, from the top down. On the last peer each level scans the
// cumulative weights, runs a division and reads two entries; a zero total or an empty
// memory gives a no-peer result for each level. Results wait in an output register.
// Depends on wpq_pkg, wpq_mem and wpq_div.
`default_nettype none
module weighted_peer_quantile import wpq_pkg::*; #(
  parameter int unsigned MAX_PEERS = 64,
  parameter int unsigned MAX_TAUS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] peer_value_i,
  input  wire logic [15:0] peer_weight_i,
  input  wire logic [21:0] weight_total_i,
  input  wire logic        last_peer_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       tau_index_o,
  output logic [31:0]      quantile_value_o,
  output logic [6:0]       low_position_o,
  output logic [6:0]       high_position_o,
  output logic [16:0]      lower_weight_o,
  output logic [16:0]      upper_weight_o,
  output logic             no_peers_o,
  output logic             last_result_o
);
  localparam int unsigned AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TauCnt = (MAX_TAUS < 4) ? MAX_TAUS : 4;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_PEERS);

  state_e state_q, state_d;
  logic [3:0]  type_q;
  logic [2:0]  ntau_q;
  logic [16:0] tau_q [4];
  logic [CW-1:0] cnt_q, cnt_d, p_q, p_d;
  logic [31:0] nval_q;
  logic [15:0] nwt_q;
  logic [21:0] d_q;
  logic        last_q;
  logic [1:0]  k_q, k_d;
  logic [2:0]  nt;
  logic [CW-1:0] l_q, l_d;
  logic [29:0] s_q, s_d, sl_q, sl_d;
  logic [21:0] den_q, den_d;
  logic [38:0] td;
  logic [16:0] tau;
  logic [3:0]  qt;
  logic [42:0] pos_q, pos_d;
  logic [6:0]  lo_q, hi_q;
  logic [16:0] w2_q;
  logic signed [31:0] ylo_q;
  logic signed [49:0] prod_lo_q, prod_hi_q;
  logic [21:0] c;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wval, rval;
  logic [15:0]   wwt, rwt;
  logic          div_start, div_busy;
  logic [38:0]   div_num, quo;

  logic        ov_q;
  logic [1:0]  o_k_q;
  logic [31:0] o_v_q;
  logic [6:0]  o_lo_q, o_hi_q;
  logic [16:0] o_w1_q, o_w2_q;
  logic        o_np_q, o_last_q;
  logic        emit;
  logic [31:0] emit_v;
  logic        emit_np;

  wpq_mem #(.Depth(MAX_PEERS), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wval_i(wval), .wwt_i(wwt),
    .raddr_i(raddr), .rval_o(rval), .rwt_o(rwt)
  );

  wpq_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(den_q),
    .busy_o(div_busy), .quo_o(quo)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign nt  = (ntau_q == 3'd0) ? 3'd1 : ((ntau_q > 3'(TauCnt)) ? 3'(TauCnt) : ntau_q);
  assign tau = (tau_q[k_q] > 17'd65536) ? 17'd65536 : tau_q[k_q];
  assign qt  = (type_q == 4'd0 || type_q > 4'd9) ? 4'd7 : type_q;
  assign td  = 39'(tau) * 39'(d_q);
  assign c   = (s_q + 30'(rwt) < 30'(d_q)) ? 22'(s_q + 30'(rwt)) : d_q;
  assign div_num = td - {sl_q[21:0], 16'd0} ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= 4'd7;
      ntau_q <= 3'd1;
      for (int i = 0; i < 4; i++) tau_q[i] <= 17'd32768;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegType:    type_q <= cfg_data_i[3:0];
        RegNumTaus: ntau_q <= cfg_data_i[2:0];
        RegTau0, RegTau1, RegTau2, RegTau3: tau_q[2'(cfg_index_i - RegTau0)] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    p_d = p_q;
    k_d = k_q;
    l_d = l_q;
    s_d = s_q;
    sl_d = sl_q;
    den_d = den_q;
    pos_d = pos_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        p_d = cnt_q;
        if (peer_weight_i != 16'd0 && cnt_q < MaxCnt) begin
          state_d = (cnt_q == '0) ? StInsert : StShiftRd;
        end else begin
          state_d = StLastChk;
        end
      end
      StShiftRd: state_d = StShiftWr;
      StShiftWr: begin
        if ($signed(rval) > $signed(nval_q)) begin
          p_d = p_q - 1'b1;
          state_d = (p_q == CW'(1)) ? StInsert : StShiftRd;
        end else begin
          state_d = StInsert;
        end
      end
      StInsert: begin
        cnt_d = cnt_q + 1'b1;
        state_d = StLastChk;
      end
      StLastChk: begin
        k_d = '0;
        if (!last_q) begin
          state_d = StIdle;
        end else if (d_q == '0 || cnt_q == '0) begin
          state_d = StNoPeer;
        end else begin
          l_d = '0; s_d = '0; sl_d = '0;
          state_d = StScanRd;
        end
      end
      StScanRd: state_d = StScanCmp;
      StScanCmp: begin
        if ({8'd0, c, 16'd0} <= 46'(td)) begin
          l_d = l_q + 1'b1;
          sl_d = 30'(c);
          s_d = s_q + 30'(rwt);
          if (l_q + 1'b1 == cnt_q) begin
            den_d = d_q;
            state_d = StDivide;
          end else begin
            state_d = StScanRd;
          end
        end else begin
          den_d = 22'(rwt);
          state_d = StDivide;
        end
      end
      StDivide: if (!div_busy && den_q != '0 && pos_q[42]) begin
        state_d = StPosition;
      end else if (!div_busy) begin
        pos_d = {1'b1, 42'd0};
      end
      StPosition: begin
        state_d = StRdLo;
      end
      StRdLo: state_d = StRdHi;
      StRdHi: state_d = StMul;
      StMul: state_d = StEmit;
      StEmit: if (!ov_q || !out_stall_i) begin
        pos_d = '0;
        if (3'(k_q) + 3'd1 == nt) begin
          cnt_d = '0;
          state_d = StIdle;
        end else begin
          k_d = k_q + 1'b1;
          l_d = '0; s_d = '0; sl_d = '0;
          state_d = StScanRd;
        end
      end
      StNoPeer: if (!ov_q || !out_stall_i) begin
        if (3'(k_q) + 3'd1 == nt) begin
          cnt_d = '0;
          state_d = StIdle;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // memory port and divider start control
  always_comb begin
    we = 1'b0;
    waddr = AW'(p_q);
    wval = rval;
    wwt = rwt;
    raddr = AW'(p_q - 1'b1);
    div_start = 1'b0;
    unique case (state_q)
      StShiftWr: we = ($signed(rval) > $signed(nval_q));
      StInsert: begin
        we = 1'b1; wval = nval_q; wwt = nwt_q;
      end
      StScanRd: raddr = AW'(l_q);
      StScanCmp: raddr = AW'(l_q);
      StDivide: div_start = !div_busy && !pos_q[42];
      StRdLo: raddr = (lo_q == 7'd0) ? '0 :
                      ((lo_q > 7'(cnt_q)) ? AW'(cnt_q - 1'b1) : AW'(lo_q - 7'd1));
      StRdHi: raddr = (hi_q == 7'd0) ? '0 :
                      ((hi_q > 7'(cnt_q)) ? AW'(cnt_q - 1'b1) : AW'(hi_q - 7'd1));
      default: ;
    endcase
  end

  // position and weight rule
  logic signed [43:0] p_raw, p_off;
  logic [26:0] j_raw;
  logic [15:0] frac;
  logic [16:0] w2;
  logic [26:0] jj;
  logic [17:0] t8_sum;
  logic [36:0] t8_prod;
  always_comb begin
    p_raw = $signed({1'b0, 27'(l_q), 16'd0}) + $signed({5'd0, quo});
    // (tau + 1) / 3 by reciprocal multiply, exact below 2^19
    t8_sum = 18'(tau) + 18'd65536;
    t8_prod = 37'(t8_sum) * 37'd174763;
    unique case (qt)
      4'd3: p_off = p_raw - 44'sd32768;
      4'd5: p_off = p_raw + 44'sd32768;
      4'd6: p_off = (tau == 17'd65536) ? $signed({1'b0, 27'(l_q), 16'd0})
                                       : p_raw + 44'($signed({1'b0, tau}));
      4'd8: p_off = p_raw + 44'(t8_prod[36:19]);
      4'd9: p_off = p_raw + 44'(tau >> 2) + 44'sd24576;
      4'd7: p_off = p_raw + 44'(17'd65536 - tau);
      default: p_off = p_raw;
    endcase
    j_raw = p_off[42:16];
    frac = p_off[15:0];
    jj = j_raw;
    if (p_off < 0) begin
      jj = '0;
      w2 = 17'd65536;
    end else begin
      unique case (qt)
        4'd1: w2 = (frac != 0) ? 17'd65536 : 17'd0;
        4'd2: w2 = (frac != 0) ? 17'd65536 : 17'd32768;
        4'd3: w2 = (!j_raw[0] && p_off >= 44'sd65536) ?
                   ((frac != 0) ? 17'd65536 : 17'd0) : 17'd65536;
        default: w2 = {1'b0, frac};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      k_q <= '0;
      pos_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      k_q <= k_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    l_q <= l_d;
    s_q <= s_d;
    sl_q <= sl_d;
    den_q <= den_d;
    if (state_q == StIdle && in_valid_i) begin
      nval_q <= peer_value_i;
      nwt_q <= peer_weight_i;
      d_q <= weight_total_i;
      last_q <= last_peer_i;
    end
    if (state_q == StPosition) begin
      lo_q <= (jj > 27'(cnt_q) + 27'd1) ? 7'(cnt_q + 1'b1) : 7'(jj);
      hi_q <= (jj + 27'd1 > 27'(cnt_q) + 27'd1) ? 7'(cnt_q + 1'b1) : 7'(jj + 27'd1);
      w2_q <= w2;
    end
    if (state_q == StRdHi) ylo_q <= $signed(rval);
    if (state_q == StMul) begin
      prod_lo_q <= ylo_q * $signed({1'b0, 17'd65536 - w2_q});
      prod_hi_q <= $signed(rval) * $signed({1'b0, w2_q});
    end
  end

  logic signed [50:0] sum;
  assign sum = 51'(prod_lo_q) + 51'(prod_hi_q);
  assign emit = (state_q == StEmit || state_q == StNoPeer) && (!ov_q || !out_stall_i);
  assign emit_np = (state_q == StNoPeer);
  assign emit_v = 32'(sum >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_k_q <= k_q;
      o_v_q <= emit_np ? '0 : emit_v;
      o_lo_q <= emit_np ? '0 : lo_q;
      o_hi_q <= emit_np ? '0 : hi_q;
      o_w1_q <= emit_np ? '0 : 17'd65536 - w2_q;
      o_w2_q <= emit_np ? '0 : w2_q;
      o_np_q <= emit_np;
      o_last_q <= (3'(k_q) + 3'd1 == nt);
    end
  end

  assign out_valid_o = ov_q;
  assign tau_index_o = o_k_q;
  assign quantile_value_o = o_v_q;
  assign low_position_o = o_lo_q;
  assign high_position_o = o_hi_q;
  assign lower_weight_o = o_w1_q;
  assign upper_weight_o = o_w2_q;
  assign no_peers_o = o_np_q;
  assign last_result_o = o_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= MaxCnt)
    else $error("peer count overflow");
  a_weights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (no_peers_o || 18'(lower_weight_o) + 18'(upper_weight_o) == 18'd65536))
    else $error("weights do not sum to one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped under stall");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !no_peers_o) |-> low_position_o <= high_position_o)
    else $error("position order");
endmodule
`default_nettype wire
